// ----- rtl/acr_pkg.sv -----
// Package with the constants, word types and divider interface of the adaptive comparator reference.
`default_nettype none

package acr_pkg;

    localparam int COUNT_BITS  = 8;
    localparam int REF_W       = 12;
    localparam int HIGH_W      = 16;
    localparam int SUM_W       = 32;
    localparam int DEV_W       = 12;
    localparam int TRIG_W      = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_W       = (COUNT_BITS > 4) ? COUNT_BITS : 4;
    localparam int CMP_W       = (COUNT_BITS > TRIG_W) ? COUNT_BITS : TRIG_W;
    localparam int DIV_STEP_W  = $clog2(SUM_W);
    // Quotients wider than this always clamp to the maximum once scaled by 0.9.
    localparam int QUOT_SMALL_W = REF_W + 1;
    localparam int Q9_W         = QUOT_SMALL_W + 4;

    localparam logic [REF_W-1:0]  REF_RESET   = REF_W'(825);
    localparam logic [DEV_W-1:0]  DEV_RESET   = DEV_W'(66);
    localparam logic [HIGH_W-1:0] CEIL_RESET  = HIGH_W'(3000);
    localparam logic [REF_W-1:0]  MAX_RESET   = REF_W'(1500);
    localparam logic [REF_W-1:0]  MIN_RESET   = REF_W'(825);
    localparam logic [TRIG_W-1:0] TRIG_RESET  = TRIG_W'(10);
    localparam logic [DIV_W-1:0]  DIV_TEN     = DIV_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVIATION = 3'd0,
        CFG_CEILING   = 3'd1,
        CFG_REF_MAX   = 3'd2,
        CFG_REF_MIN   = 3'd3,
        CFG_TRIGGER   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic              signal_present;
        logic [HIGH_W-1:0] high_level_mv;
    } t_in_word;

    typedef struct packed {
        logic [REF_W-1:0] reference_mv;
        logic             dac_write;
    } t_out_word;

    typedef struct packed {
        logic [DEV_W-1:0]  deviation_limit_mv;
        logic [HIGH_W-1:0] high_level_ceiling_mv;
        logic [REF_W-1:0]  reference_max_mv;
        logic [REF_W-1:0]  reference_min_mv;
        logic [TRIG_W-1:0] sample_trigger;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/acr_cfg_regs.sv -----
// Configuration register file of the adaptive comparator reference.
`default_nettype none

module acr_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [acr_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [acr_pkg::CFG_DATA_W-1:0] i_wr_data,
    output acr_pkg::t_cfg                      o_cfg
);

    acr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deviation_limit_mv    <= acr_pkg::DEV_RESET;
            r_cfg.high_level_ceiling_mv <= acr_pkg::CEIL_RESET;
            r_cfg.reference_max_mv      <= acr_pkg::MAX_RESET;
            r_cfg.reference_min_mv      <= acr_pkg::MIN_RESET;
            r_cfg.sample_trigger        <= acr_pkg::TRIG_RESET;
        end else if (i_wr_en) begin
            unique case (acr_pkg::t_cfg_index'(i_wr_index))
                acr_pkg::CFG_DEVIATION: begin
                    r_cfg.deviation_limit_mv <= i_wr_data[acr_pkg::DEV_W-1:0];
                end
                acr_pkg::CFG_CEILING: begin
                    r_cfg.high_level_ceiling_mv <= i_wr_data[acr_pkg::HIGH_W-1:0];
                end
                acr_pkg::CFG_REF_MAX: begin
                    r_cfg.reference_max_mv <= i_wr_data[acr_pkg::REF_W-1:0];
                end
                acr_pkg::CFG_REF_MIN: begin
                    r_cfg.reference_min_mv <= i_wr_data[acr_pkg::REF_W-1:0];
                end
                acr_pkg::CFG_TRIGGER: begin
                    r_cfg.sample_trigger <= i_wr_data[acr_pkg::TRIG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/acr_serial_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module acr_serial_div (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire acr_pkg::t_div_req i_req,
    output acr_pkg::t_div_rsp o_rsp
);

    logic [acr_pkg::SUM_W-1:0]      r_quo;
    logic [acr_pkg::DIV_W-1:0]      r_rem;
    logic [acr_pkg::DIV_W-1:0]      r_dvs;
    logic [acr_pkg::DIV_STEP_W-1:0] r_step;
    logic                           r_busy;
    logic                           r_done;

    logic [acr_pkg::DIV_W:0]   w_trial;
    logic                      w_ge;
    logic [acr_pkg::DIV_W:0]   w_diff;
    logic [acr_pkg::DIV_W-1:0] n_rem;

    // The dividend shifts out of the top of r_quo while quotient bits shift in below.
    always_comb begin
        w_trial = {r_rem, r_quo[acr_pkg::SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[acr_pkg::DIV_W-1:0] : w_trial[acr_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
            r_step <= acr_pkg::DIV_STEP_W'(acr_pkg::SUM_W - 1);
        end else if (r_busy) begin
            r_quo  <= {r_quo[acr_pkg::SUM_W-2:0], w_ge};
            r_rem  <= n_rem;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/adaptive_comparator_reference.sv -----
// Top level of the adaptive comparator reference: sequencer, state and output register.
//
//  channel  direction  handshake                word
//  in       sink       i_in_valid / o_in_stall    t_in_word  (signal_present, high_level_mv)
//  out      source     o_out_valid / i_out_stall  t_out_word (reference_mv, dac_write)
//  cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word is processed at a time; o_in_stall is high from acceptance until the result
// is loaded into the output register. A recomputation runs the serial divider twice
// (sum / count, then 9q / 10); a quotient too large to scale skips the second pass.
// Synchronous active-low reset restores the reference to 825 mV and clears the sum and
// count. A stalled result holds in the output register while the next word is already
// being worked on; that word waits in its last step until the output frees.
`default_nettype none

module adaptive_comparator_reference (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire acr_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output acr_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [acr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [acr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_SUM,
        S_DIV_TEN,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic                            r_present;
    logic [acr_pkg::HIGH_W-1:0]      r_high;
    logic [acr_pkg::REF_W-1:0]       r_ref;
    logic [acr_pkg::SUM_W-1:0]       r_sum;
    logic [acr_pkg::COUNT_BITS-1:0]  r_cnt;
    logic                            r_write;
    logic                            r_out_valid;
    acr_pkg::t_out_word              r_out_word;
    acr_pkg::t_div_req               r_div_req;

    acr_pkg::t_cfg     w_cfg;
    acr_pkg::t_div_rsp w_div_rsp;

    logic [15:0]                     w_ref10;
    logic [19:0]                     w_high9;
    logic [19:0]                     w_gap;
    logic [15:0]                     w_lim10;
    logic                            w_gap_over;
    logic                            w_below_ceil;
    logic [acr_pkg::SUM_W-1:0]       w_sum_acc;
    logic [acr_pkg::COUNT_BITS-1:0]  w_cnt_acc;
    logic                            w_recalc;
    logic [acr_pkg::Q9_W-1:0]        w_q9;
    logic                            w_quot_big;
    logic                            w_div_start;
    logic                            w_out_load;

    function automatic logic [acr_pkg::REF_W-1:0] f_clamp(
        input logic [acr_pkg::SUM_W-1:0] v,
        input logic [acr_pkg::REF_W-1:0] hi,
        input logic [acr_pkg::REF_W-1:0] lo
    );
        logic [acr_pkg::REF_W-1:0] res;
        // The maximum is tested first, so a minimum above the maximum still wins below it.
        if (v > acr_pkg::SUM_W'(hi)) begin
            res = hi;
        end else if (v < acr_pkg::SUM_W'(lo)) begin
            res = lo;
        end else begin
            res = v[acr_pkg::REF_W-1:0];
        end
        return res;
    endfunction

    acr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    acr_serial_div u_serial_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_ref10      = (16'(r_ref) << 3) + (16'(r_ref) << 1);
        w_high9      = (20'(r_high) << 3) + 20'(r_high);
        w_gap        = (20'(w_ref10) > w_high9) ? (20'(w_ref10) - w_high9)
                                                : (w_high9 - 20'(w_ref10));
        w_lim10      = (16'(w_cfg.deviation_limit_mv) << 3)
                     + (16'(w_cfg.deviation_limit_mv) << 1);
        w_gap_over   = (w_gap > 20'(w_lim10));
        w_below_ceil = (r_high < w_cfg.high_level_ceiling_mv);
        w_sum_acc    = w_below_ceil ? (r_sum + acr_pkg::SUM_W'(r_high)) : r_sum;
        w_cnt_acc    = w_below_ceil ? (r_cnt + acr_pkg::COUNT_BITS'(1)) : r_cnt;
        w_recalc     = (acr_pkg::CMP_W'(w_cnt_acc) > acr_pkg::CMP_W'(w_cfg.sample_trigger))
                     && (w_cnt_acc != '0);
        w_quot_big   = |w_div_rsp.quotient[acr_pkg::SUM_W-1:acr_pkg::QUOT_SMALL_W];
        w_q9         = (acr_pkg::Q9_W'(w_div_rsp.quotient[acr_pkg::QUOT_SMALL_W-1:0]) << 3)
                     + acr_pkg::Q9_W'(w_div_rsp.quotient[acr_pkg::QUOT_SMALL_W-1:0]);
        w_div_start  = ((r_state == S_EVAL) && r_present && w_gap_over && w_recalc)
                     || ((r_state == S_DIV_SUM) && w_div_rsp.done && !w_quot_big);
        w_out_load   = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ref           <= acr_pkg::REF_RESET;
            r_sum           <= '0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= w_div_start;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_present <= i_in_word.signal_present;
                        r_high    <= i_in_word.high_level_mv;
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_present) begin
                        r_ref   <= f_clamp(acr_pkg::SUM_W'(r_ref), w_cfg.reference_max_mv,
                                           w_cfg.reference_min_mv);
                        r_write <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (w_gap_over) begin
                        r_sum <= w_sum_acc;
                        r_cnt <= w_cnt_acc;
                        if (w_recalc) begin
                            r_div_req.dividend <= w_sum_acc;
                            r_div_req.divisor  <= acr_pkg::DIV_W'(w_cnt_acc);
                            r_state            <= S_DIV_SUM;
                        end else begin
                            r_write <= 1'b0;
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_write <= 1'b0;
                        r_state <= S_FINISH;
                    end
                end
                S_DIV_SUM: begin
                    if (w_div_rsp.done) begin
                        if (w_quot_big) begin
                            r_ref   <= w_cfg.reference_max_mv;
                            r_write <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_div_req.dividend <= acr_pkg::SUM_W'(w_q9);
                            r_div_req.divisor  <= acr_pkg::DIV_TEN;
                            r_state            <= S_DIV_TEN;
                        end
                    end
                end
                S_DIV_TEN: begin
                    if (w_div_rsp.done) begin
                        r_ref   <= f_clamp(w_div_rsp.quotient, w_cfg.reference_max_mv,
                                           w_cfg.reference_min_mv);
                        r_write <= 1'b1;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_load) begin
                        r_out_word.reference_mv <= r_ref;
                        r_out_word.dac_write    <= r_write;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/acr_checker.sv -----
// Port-level checker for the adaptive comparator reference, bound to the top level.
`default_nettype none

module acr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire acr_pkg::t_in_word              i_in_word,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire acr_pkg::t_out_word             o_out_word,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [acr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [acr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [acr_pkg::REF_W-1:0] r_last_ref;
    logic                      r_have_last;
    logic                      w_out_take;

    assign w_out_take = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (w_out_take) begin
            r_have_last <= 1'b1;
            r_last_ref  <= o_out_word.reference_mv;
        end
    end

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    // Words are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in progress");

    // An offered input word carries known bits.
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_word))
        else $error("input word has unknown bits");

    // Without a DAC write the reference is the one last reported.
    a_ref_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && !o_out_word.dac_write && r_have_last)
            |-> (o_out_word.reference_mv == r_last_ref))
        else $error("reference changed without a DAC write");

    // The configuration port is always open and takes known words.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> (o_cfg_ready && !$isunknown({i_cfg_index, i_cfg_data})))
        else $error("configuration write refused");

endmodule

bind adaptive_comparator_reference acr_checker u_acr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the adaptive comparator reference block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W          = acr_pkg::CFG_DATA_W;
    localparam int IDX_W           = acr_pkg::CFG_IDX_W;
    localparam int IDLE_MAX        = 18;
    localparam int TAIL_CYCLES     = 100;
    localparam int STALL_LIMIT     = 2000;
    localparam int SHOWN_ERRORS    = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int WRAP_ITEMS      = 258;
    localparam int SIDE_IN         = 0;
    localparam int SIDE_OUT        = 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    acr_pkg::t_in_word     i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    acr_pkg::t_out_word    o_out_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;

    // Shadow copy of the block's registers and tracking state.
    acr_pkg::t_cfg                  shadow_cfg;
    logic [acr_pkg::REF_W-1:0]      track_ref;
    logic [acr_pkg::SUM_W-1:0]      acc_sum;
    logic [acr_pkg::COUNT_BITS-1:0] acc_count;

    acr_pkg::t_out_word    pending_refs[$];
    logic [IDX_W-1:0]      cfg_idx_q[$];
    logic [DATA_W-1:0]     cfg_data_q[$];

    int                    mismatch_count;
    int                    results_seen;
    int                    idle_cycles;
    int                    gap_run_left[2];
    bit                    gap_quiet[2];

    adaptive_comparator_reference i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle gaps come in runs: some runs have no gaps at all, others draw freely.
    function automatic int draw_gap(int side);
        if (gap_run_left[side] == 0) begin
            gap_run_left[side] = $urandom_range(10, 60);
            gap_quiet[side] = ($urandom_range(0, 3) == 0);
        end
        gap_run_left[side]--;
        return gap_quiet[side] ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic void reset_shadow();
        shadow_cfg.deviation_limit_mv    = 12'd66;
        shadow_cfg.high_level_ceiling_mv = 16'd3000;
        shadow_cfg.reference_max_mv      = 12'd1500;
        shadow_cfg.reference_min_mv      = 12'd825;
        shadow_cfg.sample_trigger        = 8'd10;
        track_ref = 12'd825;
        acc_sum   = '0;
        acc_count = '0;
    endfunction

    // The max test comes first, so a minimum above the maximum still wins below it.
    function automatic logic [acr_pkg::REF_W-1:0] limit_to_window(logic [63:0] level);
        if (level > 64'(shadow_cfg.reference_max_mv)) return shadow_cfg.reference_max_mv;
        if (level < 64'(shadow_cfg.reference_min_mv)) return shadow_cfg.reference_min_mv;
        return level[acr_pkg::REF_W-1:0];
    endfunction

    function automatic acr_pkg::t_out_word next_reference(acr_pkg::t_in_word obs);
        logic [63:0]        ref_x10;
        logic [63:0]        high_x9;
        logic [63:0]        spread;
        logic [63:0]        mean;
        acr_pkg::t_out_word res;
        res.dac_write = 1'b0;
        if (!obs.signal_present) begin
            track_ref = limit_to_window(64'(track_ref));
            res.dac_write = 1'b1;
        end else begin
            ref_x10 = 64'(track_ref) * 10;
            high_x9 = 64'(obs.high_level_mv) * 9;
            spread  = (ref_x10 > high_x9) ? ref_x10 - high_x9 : high_x9 - ref_x10;
            if (spread > 64'(shadow_cfg.deviation_limit_mv) * 10) begin
                if (obs.high_level_mv < shadow_cfg.high_level_ceiling_mv) begin
                    acc_sum   += acr_pkg::SUM_W'(obs.high_level_mv);
                    acc_count += 1'b1;
                end
                if (acc_count != 0 && acc_count > shadow_cfg.sample_trigger) begin
                    mean = 64'(acc_sum / acr_pkg::SUM_W'(acc_count));
                    track_ref = limit_to_window((mean * 9) / 10);
                    res.dac_write = 1'b1;
                end
            end else begin
                acc_sum   = '0;
                acc_count = '0;
            end
        end
        res.reference_mv = track_ref;
        return res;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            acr_pkg::CFG_DEVIATION:
                shadow_cfg.deviation_limit_mv    = data[acr_pkg::DEV_W-1:0];
            acr_pkg::CFG_CEILING:
                shadow_cfg.high_level_ceiling_mv = data[acr_pkg::HIGH_W-1:0];
            acr_pkg::CFG_REF_MAX:
                shadow_cfg.reference_max_mv      = data[acr_pkg::REF_W-1:0];
            acr_pkg::CFG_REF_MIN:
                shadow_cfg.reference_min_mv      = data[acr_pkg::REF_W-1:0];
            acr_pkg::CFG_TRIGGER:
                shadow_cfg.sample_trigger        = data[acr_pkg::TRIG_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void note_error(string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) $display("%s", msg);
    endfunction

    // Bits above the register width carry random data; the block must drop them.
    function automatic logic [DATA_W-1:0] with_noise(int value, int width);
        logic [DATA_W-1:0] keep;
        keep = DATA_W'((1 << width) - 1);
        return (DATA_W'($urandom) & ~keep) | (DATA_W'(value) & keep);
    endfunction

    function automatic void stage_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_idx_q.push_back(idx);
        cfg_data_q.push_back(data);
    endfunction

    function automatic void stage_settings(int dev, int ceiling, int ref_max, int ref_min,
                                           int trigger);
        stage_write(acr_pkg::CFG_DEVIATION, with_noise(dev, acr_pkg::DEV_W));
        stage_write(acr_pkg::CFG_CEILING, DATA_W'(ceiling));
        stage_write(acr_pkg::CFG_REF_MAX, with_noise(ref_max, acr_pkg::REF_W));
        stage_write(acr_pkg::CFG_REF_MIN, with_noise(ref_min, acr_pkg::REF_W));
        stage_write(acr_pkg::CFG_TRIGGER, with_noise(trigger, acr_pkg::TRIG_W));
    endfunction

    function automatic int pick_setting(int lo, int hi, int full);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return full;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic void stage_random_settings();
        int lo_mv;
        int hi_mv;
        int swap;
        lo_mv = pick_setting(0, 3300, 4095);
        hi_mv = pick_setting(0, 3300, 4095);
        // Keep the window mostly well ordered; an inverted one is still seen now and then.
        if (lo_mv > hi_mv && $urandom_range(0, 4) != 0) begin
            swap  = lo_mv;
            lo_mv = hi_mv;
            hi_mv = swap;
        end
        stage_settings(pick_setting(0, 200, 4095), pick_setting(200, 4000, 65535),
                       hi_mv, lo_mv, pick_setting(0, 20, 255));
        for (int idx = int'(acr_pkg::CFG_TRIGGER) + 1; idx < (1 << IDX_W); idx++) begin
            stage_write(IDX_W'(idx), DATA_W'($urandom));
        end
    endfunction

    task automatic send_observation(input logic present,
                                    input logic [acr_pkg::HIGH_W-1:0] high);
        int                pause;
        acr_pkg::t_in_word obs;
        obs.signal_present = present;
        obs.high_level_mv  = high;
        pause = draw_gap(SIDE_IN);
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= obs;
        do @(posedge i_clk); while (o_in_stall);
        pending_refs.push_back(next_reference(obs));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_refs.size() != 0) @(posedge i_clk);
    endtask

    task automatic commit_register_writes();
        wait_for_results();
        while (cfg_idx_q.size() != 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_idx_q[0];
            i_cfg_data  <= cfg_data_q[0];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_register(cfg_idx_q.pop_front(), cfg_data_q.pop_front());
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_observation();
        int kind;
        int center;
        int span;
        int ceiling;
        int value;
        kind    = $urandom_range(0, 99);
        ceiling = int'(shadow_cfg.high_level_ceiling_mv);
        if (kind < 10) begin
            send_observation(1'b0, acr_pkg::HIGH_W'($urandom));
        end else if (kind < 25) begin
            // Close to the reference, so the running average is cleared.
            center = (int'(track_ref) * 10) / 9;
            span   = int'(shadow_cfg.deviation_limit_mv);
            value  = center - span + int'($urandom_range(0, 2 * span));
            if (value < 0) value = 0;
            if (value > 65535) value = 65535;
            send_observation(1'b1, acr_pkg::HIGH_W'(value));
        end else if (kind < 85) begin
            value = (ceiling == 0) ? int'($urandom_range(0, 65535))
                                   : int'($urandom_range(0, ceiling - 1));
            send_observation(1'b1, acr_pkg::HIGH_W'(value));
        end else if (kind < 95) begin
            send_observation(1'b1, acr_pkg::HIGH_W'($urandom_range(ceiling, 65535)));
        end else begin
            send_observation(1'b1, acr_pkg::HIGH_W'($urandom));
        end
    endtask

    task automatic test_reset_state();
        send_observation(1'b0, 16'hFFFF);
        send_observation(1'b1, 16'd917);
        send_observation(1'b1, 16'd0);
        send_observation(1'b1, 16'hFFFF);
        send_observation(1'b1, 16'd2999);
        send_observation(1'b1, 16'd3000);
        send_observation(1'b1, 16'h5555);
        send_observation(1'b1, 16'hAAAA);
    endtask

    task automatic test_register_limits();
        // Minimum above maximum: the reference swings between the two bounds.
        stage_settings(66, 3000, 1000, 2000, 10);
        commit_register_writes();
        repeat (3) send_observation(1'b0, 16'd0);
        stage_settings(4095, 0, 4095, 0, 255);
        commit_register_writes();
        send_observation(1'b1, 16'hFFFF);
        send_observation(1'b1, 16'd0);
        send_observation(1'b0, 16'hFFFF);
        stage_settings(0, 65535, 0, 0, 0);
        commit_register_writes();
        send_observation(1'b0, 16'd0);
        send_observation(1'b1, 16'd0);
        send_observation(1'b1, 16'd1);
        stage_settings(0, 65535, 4095, 4095, 0);
        commit_register_writes();
        send_observation(1'b0, 16'd0);
    endtask

    task automatic test_recompute();
        stage_settings(10, 3000, 3300, 0, 2);
        commit_register_writes();
        send_observation(1'b1, acr_pkg::HIGH_W'((int'(track_ref) * 10) / 9));
        send_observation(1'b1, 16'd2000);
        send_observation(1'b1, 16'd2500);
        send_observation(1'b1, 16'd2999);
        send_observation(1'b1, 16'd400);
        send_observation(1'b1, acr_pkg::HIGH_W'((int'(track_ref) * 10) / 9));
        send_observation(1'b0, 16'd1234);
    endtask

    // With a trigger of zero every accumulation recomputes, except when the count
    // wraps to zero; right after the wrap the quotient is very large.
    task automatic test_count_wrap();
        stage_settings(0, 65535, 4095, 0, 0);
        commit_register_writes();
        repeat (WRAP_ITEMS) begin
            send_observation(1'b1, acr_pkg::HIGH_W'($urandom_range(60000, 65534)));
        end
        send_observation(1'b1, 16'd0);
        send_observation(1'b1, 16'd100);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            stage_random_settings();
            commit_register_writes();
            repeat (ITEMS_PER_PHASE) send_random_observation();
        end
    endtask

    task automatic check_result(acr_pkg::t_out_word got);
        acr_pkg::t_out_word want;
        results_seen++;
        if (pending_refs.size() == 0) begin
            note_error($sformatf("result %0d: nothing expected, got reference %0d dac %0b",
                                 results_seen, got.reference_mv, got.dac_write));
            return;
        end
        want = pending_refs.pop_front();
        if (got.reference_mv !== want.reference_mv) begin
            note_error($sformatf("result %0d: reference_mv expected %0d, got %0d",
                                 results_seen, want.reference_mv, got.reference_mv));
        end
        if (got.dac_write !== want.dac_write) begin
            note_error($sformatf("result %0d: dac_write expected %0b, got %0b",
                                 results_seen, want.dac_write, got.dac_write));
        end
    endtask

    initial begin : result_checker
        int hold;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = draw_gap(SIDE_OUT);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            check_result(o_out_word);
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mismatch_count = 0;
        results_seen   = 0;
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_limits();
        test_recompute();
        test_count_wrap();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_refs.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", pending_refs.size()));
        end
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
